### rtl/nrt_pkg.sv
package nrt_pkg;

  localparam int NAME_MAX_BYTES = 16;
  localparam int BYTE_W         = 8;
  localparam int NAME_W         = 64;
  localparam int PORT_W         = 16;
  localparam int TASK_W         = 16;
  localparam int OPCODE_W       = 2;
  localparam int STATUS_W       = 3;

  // Request opcodes
  localparam logic [OPCODE_W-1:0] OP_REGISTER   = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_UNREGISTER = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_FIND       = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DUP      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_INVALID  = 3'd4;

  // Request fields broadcast to every cell while a scan runs
  typedef struct packed {
    logic [NAME_W-1:0] name_high;
    logic [NAME_W-1:0] name_low;
    logic [PORT_W-1:0] port_id;
    logic [TASK_W-1:0] task_id;
  } req_t;

  // Running scan results handed from cell to cell
  typedef struct packed {
    logic              hit;
    logic              owner_ok;
    logic              free_seen;
    logic [PORT_W-1:0] hit_port;
  } scan_t;

  // Table update issued once the scan has left the last cell
  typedef struct packed {
    logic install;
    logic clear;
  } commit_t;

endpackage

### rtl/nrt_cell.sv
module nrt_cell import nrt_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  req_t    req,
  input  commit_t commit,
  input  logic    scan_vin,
  input  scan_t   scan_in,
  output logic    scan_vout,
  output scan_t   scan_out
);

  // Slot contents
  logic [NAME_W-1:0] slot_name_high;
  logic [NAME_W-1:0] slot_name_low;
  logic [PORT_W-1:0] slot_port;
  logic [TASK_W-1:0] slot_owner;
  logic              slot_used;

  // Marks left by the passing scan: this slot matched / is the first free one
  logic hit_here;
  logic free_here;

  logic  scan_v;
  scan_t scan_q;

  logic  name_eq;
  logic  hit_here_next;
  logic  free_here_next;
  scan_t scan_next;

  // Compare against the broadcast request and fold into the running result
  always_comb begin
    name_eq        = slot_used && (slot_name_high == req.name_high) &&
                     (slot_name_low == req.name_low);
    hit_here_next  = name_eq && !scan_in.hit;
    free_here_next = !slot_used && !scan_in.free_seen;
    scan_next.hit       = scan_in.hit | name_eq;
    scan_next.free_seen = scan_in.free_seen | !slot_used;
    scan_next.hit_port  = hit_here_next ? slot_port : scan_in.hit_port;
    scan_next.owner_ok  = hit_here_next ? (slot_owner == req.task_id)
                                        : scan_in.owner_ok;
  end

  // Token valid moves one cell per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_v <= 1'b0;
    end else begin
      scan_v <= scan_vin;
    end
  end

  always_ff @(posedge clk) begin
    if (scan_vin) begin
      scan_q    <= scan_next;
      hit_here  <= hit_here_next;
      free_here <= free_here_next;
    end
  end

  // Occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_used <= 1'b0;
    end else if (commit.install && free_here) begin
      slot_used <= 1'b1;
    end else if (commit.clear && hit_here) begin
      slot_used <= 1'b0;
    end
  end

  // Slot payload written on install
  always_ff @(posedge clk) begin
    if (commit.install && free_here) begin
      slot_name_high <= req.name_high;
      slot_name_low  <= req.name_low;
      slot_port      <= req.port_id;
      slot_owner     <= req.task_id;
    end
  end

  assign scan_vout = scan_v;
  assign scan_out  = scan_q;

endmodule

### rtl/name_registry_table.sv
// Name registry table: ENTRIES slots, each binding a name of up to NAME_BYTES
// bytes (cut at its first zero byte) to a port id and an owner task id. Ops are
// register, unregister and find; one transaction is handled at a time. Each
// request sends a scan token down a row of ENTRIES slot cells, one cell per
// cycle, then the table update is applied and the result is queued. A result
// passes from a pending register to the output register. The next request
// is accepted only once the scan has left the last cell and the pending
// result has moved to the output register. One finished result may wait on
// the output while the next request is scanned. The table comes out of reset
// empty, with no fill pass.
module name_registry_table import nrt_pkg::*; #(
  parameter int ENTRIES    = 128,
  parameter int NAME_BYTES = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [OPCODE_W-1:0] opcode,
  input  logic [NAME_W-1:0]   name_high,
  input  logic [NAME_W-1:0]   name_low,
  input  logic [PORT_W-1:0]   port_id,
  input  logic [TASK_W-1:0]   task_id,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] status,
  output logic [PORT_W-1:0]   found_port
);

  req_t                req;
  logic [OPCODE_W-1:0] req_op;
  logic                launch;
  logic                busy;
  logic                pend_valid;
  logic [STATUS_W-1:0] pend_status;
  logic [PORT_W-1:0]   pend_port;

  logic                in_accept;
  logic [2*NAME_W-1:0] raw_name;
  logic [2*NAME_W-1:0] canon;

  logic                tok_v [ENTRIES+1];
  scan_t               tok   [ENTRIES+1];
  logic                tail;
  scan_t               tail_scan;

  logic [STATUS_W-1:0] res_status;
  logic [PORT_W-1:0]   res_port;
  logic                do_install;
  logic                do_clear;
  commit_t             commit;

  assign in_ready  = !busy && !pend_valid;
  assign in_accept = in_valid && in_ready;

  // Canonical name: bytes after the first zero byte or past NAME_BYTES read as zero
  assign raw_name = {name_high, name_low};
  always_comb begin
    logic alive;
    alive = 1'b1;
    canon = '0;
    for (int i = 0; i < NAME_MAX_BYTES; i++) begin
      if (i >= NAME_BYTES || raw_name[2*NAME_W-1-BYTE_W*i -: BYTE_W] == '0) begin
        alive = 1'b0;
      end
      if (alive) begin
        canon[2*NAME_W-1-BYTE_W*i -: BYTE_W] = raw_name[2*NAME_W-1-BYTE_W*i -: BYTE_W];
      end
    end
  end

  // Request capture
  always_ff @(posedge clk) begin
    if (in_accept) begin
      req.name_high <= canon[2*NAME_W-1:NAME_W];
      req.name_low  <= canon[NAME_W-1:0];
      req.port_id   <= port_id;
      req.task_id   <= task_id;
      req_op        <= opcode;
    end
  end

  // Scan control
  always_ff @(posedge clk) begin
    if (rst) begin
      launch <= 1'b0;
      busy   <= 1'b0;
    end else begin
      launch <= in_accept;
      if (in_accept) begin
        busy <= 1'b1;
      end else if (tail) begin
        busy <= 1'b0;
      end
    end
  end

  // Row of slot cells
  assign tok_v[0] = launch;
  assign tok[0]   = '0;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    nrt_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .req       (req),
      .commit    (commit),
      .scan_vin  (tok_v[g]),
      .scan_in   (tok[g]),
      .scan_vout (tok_v[g+1]),
      .scan_out  (tok[g+1])
    );
  end

  assign tail      = tok_v[ENTRIES];
  assign tail_scan = tok[ENTRIES];

  // Outcome of the finished scan
  always_comb begin
    res_status = ST_INVALID;
    res_port   = '0;
    do_install = 1'b0;
    do_clear   = 1'b0;
    case (req_op)
      OP_REGISTER: begin
        if (req.port_id == '0) begin
          res_status = ST_INVALID;
        end else if (tail_scan.hit) begin
          res_status = ST_DUP;
        end else if (!tail_scan.free_seen) begin
          res_status = ST_FULL;
        end else begin
          res_status = ST_OK;
          do_install = 1'b1;
        end
      end
      OP_UNREGISTER: begin
        if (!tail_scan.hit) begin
          res_status = ST_NOTFOUND;
        end else begin
          res_port = tail_scan.hit_port;
          if (tail_scan.owner_ok) begin
            res_status = ST_OK;
            do_clear   = 1'b1;
          end else begin
            res_status = ST_INVALID;
          end
        end
      end
      OP_FIND: begin
        if (!tail_scan.hit) begin
          res_status = ST_NOTFOUND;
        end else begin
          res_status = ST_OK;
          res_port   = tail_scan.hit_port;
        end
      end
      default: begin
        res_status = ST_INVALID;
      end
    endcase
  end

  assign commit.install = tail && do_install;
  assign commit.clear   = tail && do_clear;

  // Pending result and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (pend_valid && (!out_valid || out_ready)) begin
        out_valid  <= 1'b1;
        pend_valid <= 1'b0;
      end
      if (tail) begin
        pend_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tail) begin
      pend_status <= res_status;
      pend_port   <= res_port;
    end
    if (pend_valid && (!out_valid || out_ready)) begin
      status     <= pend_status;
      found_port <= pend_port;
    end
  end

endmodule

### rtl/nrt_checker.sv
module nrt_checker import nrt_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [STATUS_W-1:0] status,
  input logic [PORT_W-1:0]   found_port
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(found_port))
    else $error("result changed while stalled");

  // One request in flight: no accept right after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while busy");

  // Failed lookups, duplicates and full-table refusals carry no port
  a_no_port: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_DUP || status == ST_FULL || status == ST_NOTFOUND)
      |-> found_port == '0)
    else $error("port returned with a failing status");

  // Status codes stay in range
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= ST_INVALID)
    else $error("status code out of range");

  // Reset leaves the block empty and ready
  a_reset: assert property (@(posedge clk) rst |=> !out_valid && in_ready)
    else $error("not idle after reset");

endmodule

bind name_registry_table nrt_checker u_nrt_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .status     (status),
  .found_port (found_port)
);

### tb/tb_name_registry_table.sv
module tb_name_registry_table;
  timeunit 1ns;
  timeprecision 1ps;

  import nrt_pkg::*;

  localparam int SLOTS        = 128;
  localparam int NBYTES       = 16;
  localparam int POOL_NAMES   = 140;
  localparam int MIXED_ITEMS  = 440;
  localparam int TAIL_ITEMS   = 60;
  localparam int HOLD_AT      = 60;
  localparam int HOLD_CYCLES  = 2000;
  localparam int SETTLE       = 300;
  localparam int CYCLE_LIMIT  = 600000;

  // Opcode 3 has no meaning in the block; it must be answered as invalid
  localparam logic [OPCODE_W-1:0] OP_RESERVED = 2'd3;

  typedef struct {
    logic [OPCODE_W-1:0] op;
    logic [NAME_W-1:0]   name_hi;
    logic [NAME_W-1:0]   name_lo;
    logic [PORT_W-1:0]   port;
    logic [TASK_W-1:0]   owner;
    bit                  drain;   // hold this one back until all results are in
  } reg_req_t;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [PORT_W-1:0]   port;
  } reg_resp_t;

  logic                clk        = 1'b0;
  logic                rst        = 1'b1;
  logic                in_valid   = 1'b0;
  logic                in_ready;
  logic [OPCODE_W-1:0] opcode     = '0;
  logic [NAME_W-1:0]   name_high  = '0;
  logic [NAME_W-1:0]   name_low   = '0;
  logic [PORT_W-1:0]   port_id    = '0;
  logic [TASK_W-1:0]   task_id    = '0;
  logic                out_valid;
  logic                out_ready  = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [PORT_W-1:0]   found_port;

  reg_req_t  pending_reqs[$];
  reg_resp_t expected_resps[$];
  reg_req_t  cur_req;

  // Shadow copy of the registry
  logic [127:0]      bound_name[SLOTS];
  logic [PORT_W-1:0] bound_port[SLOTS];
  logic [TASK_W-1:0] bound_owner[SLOTS];
  bit                bound_used[SLOTS];

  // Name pool used to get hits, duplicates and a full table
  logic [127:0]      pool_name[POOL_NAMES];
  int                pool_len[POOL_NAMES];
  logic [TASK_W-1:0] pool_owner[POOL_NAMES];

  int   n_accepted = 0;
  int   n_checked  = 0;
  int   n_errors   = 0;
  int   n_cycles   = 0;
  int   seen_in    = 0;
  int   hold_cnt   = 0;
  logic hold_on    = 1'b0;
  logic hold_done  = 1'b0;
  logic quiet_tail = 1'b0;

  name_registry_table #(
    .ENTRIES    (SLOTS),
    .NAME_BYTES (NBYTES)
  ) uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .opcode     (opcode),
    .name_high  (name_high),
    .name_low   (name_low),
    .port_id    (port_id),
    .task_id    (task_id),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .found_port (found_port)
  );

  always #5 clk = ~clk;

  function automatic void flag_error(string msg);
    n_errors++;
    if (n_errors <= 10) $display("ERROR @%0t: %s", $time, msg);
  endfunction

  // Name as the table sees it: cut at the first zero byte and at NBYTES
  function automatic logic [127:0] trim_name(logic [127:0] nm);
    logic [127:0] r;
    bit ended;
    r = '0;
    ended = 1'b0;
    for (int i = 0; i < 16; i++) begin
      if (i >= NBYTES || nm[127-8*i -: 8] == 8'h00) ended = 1'b1;
      if (!ended) r[127-8*i -: 8] = nm[127-8*i -: 8];
    end
    return r;
  endfunction

  // Expected outcome of one request; updates the shadow registry
  function automatic reg_resp_t registry_apply(reg_req_t q);
    reg_resp_t    r;
    logic [127:0] key;
    int           hit;
    int           free_slot;
    key = trim_name({q.name_hi, q.name_lo});
    hit = -1;
    free_slot = -1;
    for (int k = 0; k < SLOTS; k++) begin
      if (bound_used[k] && bound_name[k] == key && hit < 0) hit = k;
      if (!bound_used[k] && free_slot < 0) free_slot = k;
    end
    r.status = ST_INVALID;
    r.port   = '0;
    case (q.op)
      OP_REGISTER: begin
        if (q.port == '0) begin
          r.status = ST_INVALID;
        end else if (hit >= 0) begin
          r.status = ST_DUP;
        end else if (free_slot < 0) begin
          r.status = ST_FULL;
        end else begin
          bound_name[free_slot]  = key;
          bound_port[free_slot]  = q.port;
          bound_owner[free_slot] = q.owner;
          bound_used[free_slot]  = 1'b1;
          r.status = ST_OK;
        end
      end
      OP_UNREGISTER: begin
        if (hit < 0) begin
          r.status = ST_NOTFOUND;
        end else begin
          r.port = bound_port[hit];
          if (bound_owner[hit] != q.owner) begin
            r.status = ST_INVALID;
          end else begin
            bound_name[hit]  = '0;
            bound_port[hit]  = '0;
            bound_owner[hit] = '0;
            bound_used[hit]  = 1'b0;
            r.status = ST_OK;
          end
        end
      end
      OP_FIND: begin
        if (hit < 0) begin
          r.status = ST_NOTFOUND;
        end else begin
          r.port   = bound_port[hit];
          r.status = ST_OK;
        end
      end
      default: r.status = ST_INVALID;
    endcase
    return r;
  endfunction

  function automatic void add_req(logic [OPCODE_W-1:0] op, logic [127:0] nm,
                                  logic [PORT_W-1:0] port, logic [TASK_W-1:0] owner,
                                  bit drain = 1'b0);
    reg_req_t q;
    q.op      = op;
    q.name_hi = nm[127:64];
    q.name_lo = nm[63:0];
    q.port    = port;
    q.owner   = owner;
    q.drain   = drain;
    pending_reqs.push_back(q);
  endfunction

  // Random garbage in every byte after the terminator
  function automatic logic [127:0] add_junk(logic [127:0] nm, int len);
    logic [127:0] r;
    r = nm;
    for (int i = len + 1; i < 16; i++) r[127-8*i -: 8] = 8'($urandom);
    return r;
  endfunction

  function automatic logic [127:0] make_name(int len);
    logic [127:0] nm;
    nm = '0;
    for (int i = 0; i < len && i < 16; i++) nm[127-8*i -: 8] = 8'($urandom_range(1, 255));
    return nm;
  endfunction

  // Stimulus build, reset and end of run
  initial begin
    logic [127:0]      nm;
    logic [OPCODE_W-1:0] op;
    logic [PORT_W-1:0] port;
    logic [TASK_W-1:0] owner;
    int                idx;
    int                pick;
    bit                from_pool;

    for (int k = 0; k < SLOTS; k++) begin
      bound_name[k]  = '0;
      bound_port[k]  = '0;
      bound_owner[k] = '0;
      bound_used[k]  = 1'b0;
    end

    // Directed: empty table, duplicates through junk, port zero, reserved op,
    // owner mismatch, empty and full-length names, trailing junk in name_low
    add_req(OP_FIND,       '0, 16'h0000, 16'h0000);
    add_req(OP_UNREGISTER, 128'h41 << 120, 16'h0000, 16'h0000);
    add_req(OP_REGISTER,   128'h41 << 120, 16'hFFFF, 16'hFFFF);
    add_req(OP_REGISTER,   128'h4100A5FF_12345678_FFFFFFFF_FFFFFFFF, 16'h0001, 16'h0000);
    add_req(OP_FIND,       128'h4100A5FF_12345678_FFFFFFFF_FFFFFFFF, 16'h0000, 16'h0000);
    add_req(OP_REGISTER,   {$urandom, $urandom, $urandom, $urandom}, 16'h0000, 16'hFFFF);
    add_req(OP_RESERVED,   {$urandom, $urandom, $urandom, $urandom}, 16'hFFFF, 16'hFFFF);
    add_req(OP_REGISTER,   {128{1'b1}}, 16'h0001, 16'h0000);
    add_req(OP_FIND,       {128{1'b1}}, 16'h0000, 16'h0000);
    add_req(OP_UNREGISTER, {128{1'b1}}, 16'h0000, 16'h0001);
    add_req(OP_UNREGISTER, {128{1'b1}}, 16'hFFFF, 16'h0000);
    add_req(OP_UNREGISTER, {128{1'b1}}, 16'h0000, 16'h0000);
    add_req(OP_FIND,       {128{1'b1}}, 16'h0000, 16'h0000);
    add_req(OP_REGISTER,   '0, 16'h8000, 16'h1234);
    add_req(OP_FIND,       {64'h0, $urandom, $urandom}, 16'h0000, 16'h1234);
    add_req(OP_REGISTER,   128'h41424344_45464748_00FFFFFF_FFFFFFFF, 16'h7FFF, 16'h5555);
    add_req(OP_FIND,       128'h41424344_45464748_00000000_00000000, 16'h0000, 16'h0000);
    add_req(OP_FIND,       128'h41424344_45464748_41000000_00000000, 16'h0000, 16'h0000);
    add_req(OP_UNREGISTER, '0, 16'h0000, 16'h1234);
    add_req(OP_FIND,       '0, 16'h0000, 16'h0000);
    add_req(OP_UNREGISTER, 128'h41 << 120, 16'h0000, 16'hFFFF);
    add_req(OP_RESERVED,   {128{1'b1}}, 16'h0000, 16'h0000);

    // Fill: more registrations than slots, so the table runs full
    for (int i = 0; i < POOL_NAMES; i++) begin
      pool_len[i]   = $urandom_range(1, 16);
      pool_name[i]  = make_name(pool_len[i]);
      pool_owner[i] = 16'($urandom);
      nm = ($urandom_range(0, 1) == 0) ? pool_name[i] : add_junk(pool_name[i], pool_len[i]);
      add_req(OP_REGISTER, nm, 16'($urandom_range(1, 65535)), pool_owner[i], i == 0);
    end

    // Mixed traffic, mostly on pool names, with some noise
    for (int j = 0; j < MIXED_ITEMS; j++) begin
      from_pool = ($urandom_range(0, 9) < 8);
      idx = $urandom_range(0, POOL_NAMES - 1);
      if (from_pool) begin
        nm = ($urandom_range(0, 9) < 3) ? add_junk(pool_name[idx], pool_len[idx])
                                         : pool_name[idx];
      end else if ($urandom_range(0, 1) == 0) begin
        nm = {$urandom, $urandom, $urandom, $urandom};
      end else begin
        pick = $urandom_range(0, 16);
        nm = add_junk(make_name(pick), pick);
      end
      port = 16'($urandom_range(1, 65535));
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        op = OP_REGISTER;
        owner = (from_pool && $urandom_range(0, 9) < 9) ? pool_owner[idx] : 16'($urandom);
      end else if (pick < 65) begin
        op = OP_UNREGISTER;
        owner = (from_pool && $urandom_range(0, 9) < 7) ? pool_owner[idx] : 16'($urandom);
      end else if (pick < 90) begin
        op = OP_FIND;
        owner = 16'($urandom);
      end else if (pick < 95) begin
        op = OP_RESERVED;
        owner = 16'($urandom);
        port  = 16'($urandom);
      end else begin
        op = OP_REGISTER;
        owner = pool_owner[idx];
        port  = '0;
      end
      add_req(op, nm, port, owner, j == 0 || j == MIXED_ITEMS / 2);
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (pending_reqs.size() != 0 || in_valid || n_checked != n_accepted) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (expected_resps.size() != 0)
      flag_error($sformatf("%0d results never arrived", expected_resps.size()));

    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Request driver: one transaction at a time from the pending queue
  always @(posedge clk) begin : drive_p
    bit launch;
    int gap_left;
    bit send_calm;
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      launch = 1'b0;
      if (in_valid && in_ready) begin
        expected_resps.push_back(registry_apply(cur_req));
        n_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_reqs.size() != 0 &&
                     (!pending_reqs[0].drain || n_accepted == n_checked)) begin
          launch = 1'b1;
        end
        if (launch) begin
          cur_req = pending_reqs.pop_front();
          opcode    <= cur_req.op;
          name_high <= cur_req.name_hi;
          name_low  <= cur_req.name_lo;
          port_id   <= cur_req.port;
          task_id   <= cur_req.owner;
          if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
          if (!quiet_tail && !send_calm && $urandom_range(0, 2) == 0)
            gap_left = $urandom_range(1, 15);
        end
        in_valid <= launch;
      end
      quiet_tail <= (pending_reqs.size() < TAIL_ITEMS);
    end
  end

  // Result checker with random output stalls
  always @(posedge clk) begin : check_p
    reg_resp_t want;
    bit stall;
    int stall_left;
    bit recv_calm;
    if (rst) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_resps.size() == 0) begin
          flag_error($sformatf("unexpected result status %0d port %h", status, found_port));
        end else begin
          want = expected_resps.pop_front();
          if (status !== want.status || found_port !== want.port)
            flag_error($sformatf("result %0d: status exp %0d got %0d, port exp %h got %h",
                                 n_checked, want.status, status, want.port, found_port));
        end
        n_checked <= n_checked + 1;
      end
      if ($urandom_range(0, 299) == 0) recv_calm = !recv_calm;
      if (stall_left > 0) begin
        stall_left--;
        stall = 1'b1;
      end else if (!quiet_tail && !recv_calm && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 15) - 1;
        stall = 1'b1;
      end else begin
        stall = 1'b0;
      end
      out_ready <= !(stall || hold_on);
    end
  end

  // One long output hold-off so the block backs up and stalls its input
  always @(posedge clk) begin
    if (rst) begin
      hold_on <= 1'b0;
      seen_in <= 0;
    end else begin
      if (in_valid && in_ready) seen_in <= seen_in + 1;
      if (!hold_done && seen_in == HOLD_AT) begin
        hold_on   <= 1'b1;
        hold_done <= 1'b1;
        hold_cnt  <= HOLD_CYCLES;
      end else if (hold_on) begin
        if (hold_cnt == 1) hold_on <= 1'b0;
        hold_cnt <= hold_cnt - 1;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

endmodule

### sim.f
rtl/nrt_pkg.sv
rtl/nrt_cell.sv
rtl/name_registry_table.sv
rtl/nrt_checker.sv
tb/tb_name_registry_table.sv
